>>> rtl/lzx_pretree_length_run_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LZX pretree length run encoder
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef LZX_PRETREE_LENGTH_RUN_ENCODER_UNIT_ASSERT_SVH
`define LZX_PRETREE_LENGTH_RUN_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpre_pkg.sv
// ----------------------------------------------------------------------------
// lpre_pkg
// Types, constants and helper functions of the pretree length run encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lpre_pkg;

    localparam int unsigned LPRE_QUEUE_DEPTH = 4;
    localparam int unsigned LPRE_MAX_RESULTS = 5;
    localparam int unsigned LPRE_HIST_DEPTH  = 4;

    // pretree symbol codes
    localparam logic [4:0] LPRE_SYM_ZRUN_SHORT = 5'd17;
    localparam logic [4:0] LPRE_SYM_ZRUN_LONG  = 5'd18;
    localparam logic [4:0] LPRE_SYM_SAME_RUN   = 5'd19;

    // run limits
    localparam logic [5:0] LPRE_RUN_MIN        = 6'd4;
    localparam logic [5:0] LPRE_ZRUN_SHORT_MAX = 6'h13;
    localparam logic [5:0] LPRE_ZRUN_LONG_BASE = 6'd20;
    localparam logic [5:0] LPRE_ZRUN_MAX       = 6'h33;
    localparam logic [5:0] LPRE_SRUN_MAX       = 6'd5;
    localparam logic [5:0] LPRE_FLUSH_RUN_MIN  = 6'd5;

    // extra bit widths
    localparam logic [2:0] LPRE_EW_NONE  = 3'd0;
    localparam logic [2:0] LPRE_EW_SAME  = 3'd1;
    localparam logic [2:0] LPRE_EW_SHORT = 3'd4;
    localparam logic [2:0] LPRE_EW_LONG  = 3'd5;

    typedef struct packed {
        logic [4:0] symbol;
        logic [4:0] extra_value;
        logic [2:0] extra_width;
        logic [4:0] run_delta;
        logic       done;
    } lpre_result_t;

    // one queue transaction: all results caused by one input item
    typedef struct packed {
        logic [2:0]                             count;
        lpre_result_t [LPRE_MAX_RESULTS-1:0]    slot;
    } lpre_cmd_t;

    // (prev - val) mod 17 on the raw 5-bit values
    function automatic logic [4:0] lpre_delta(logic [4:0] prev, logic [4:0] val);
        logic [6:0] s;
        s = {2'b00, prev} + 7'd34 - {2'b00, val};
        if (s >= 7'd51)
            s = s - 7'd51;
        else if (s >= 7'd34)
            s = s - 7'd34;
        else if (s >= 7'd17)
            s = s - 7'd17;
        return s[4:0];
    endfunction

    function automatic lpre_result_t lpre_result(logic [4:0] sym, logic [4:0] ev,
                                                 logic [2:0] ew, logic [4:0] rd);
        lpre_result_t r;
        r.symbol      = sym;
        r.extra_value = ev;
        r.extra_width = ew;
        r.run_delta   = rd;
        r.done        = 1'b0;
        return r;
    endfunction

    function automatic lpre_cmd_t lpre_append(lpre_cmd_t c, lpre_result_t r);
        lpre_cmd_t o;
        o = c;
        if (c.count < 3'(LPRE_MAX_RESULTS))
        begin
            o.slot[c.count] = r;
            o.count         = c.count + 3'd1;
        end
        return o;
    endfunction

    // Results of closing a pending run; h0 is the element just before latest.
    function automatic lpre_cmd_t lpre_flush(logic [5:0] len, logic [4:0] value,
                                             logic [4:0] latest, logic [4:0] h0,
                                             logic [4:0] h1, logic [4:0] h2,
                                             logic [4:0] h3);
        lpre_cmd_t  c;
        logic [5:0] r;
        logic [5:0] r_short;
        logic [5:0] r_long;
        c = '0;
        r = len - 6'd1;
        if (r > LPRE_ZRUN_MAX)
            r = LPRE_ZRUN_MAX;
        r_short = r - LPRE_RUN_MIN;
        r_long  = r - LPRE_ZRUN_LONG_BASE;
        if (len >= LPRE_FLUSH_RUN_MIN)
        begin
            if (value == 5'd0)
            begin
                if (r <= LPRE_ZRUN_SHORT_MAX)
                    c.slot[0] = lpre_result(LPRE_SYM_ZRUN_SHORT, r_short[4:0],
                                            LPRE_EW_SHORT, 5'd0);
                else
                    c.slot[0] = lpre_result(LPRE_SYM_ZRUN_LONG, r_long[4:0],
                                            LPRE_EW_LONG, 5'd0);
            end
            else
            begin
                c.slot[0] = lpre_result(LPRE_SYM_SAME_RUN, 5'd0, LPRE_EW_SAME,
                                        lpre_delta(h3, value));
            end
            c.slot[1] = lpre_result(lpre_delta(latest, value), 5'd0, LPRE_EW_NONE, 5'd0);
            c.count   = 3'd2;
        end
        else
        begin
            // short run: plain deltas, oldest first
            case (len[2:0])
                3'd1:
                begin
                    c.slot[0] = lpre_result(lpre_delta(latest, value), 5'd0, LPRE_EW_NONE, 5'd0);
                end
                3'd2:
                begin
                    c.slot[0] = lpre_result(lpre_delta(h0, value), 5'd0, LPRE_EW_NONE, 5'd0);
                    c.slot[1] = lpre_result(lpre_delta(latest, value), 5'd0, LPRE_EW_NONE, 5'd0);
                end
                3'd3:
                begin
                    c.slot[0] = lpre_result(lpre_delta(h1, value), 5'd0, LPRE_EW_NONE, 5'd0);
                    c.slot[1] = lpre_result(lpre_delta(h0, value), 5'd0, LPRE_EW_NONE, 5'd0);
                    c.slot[2] = lpre_result(lpre_delta(latest, value), 5'd0, LPRE_EW_NONE, 5'd0);
                end
                3'd4:
                begin
                    c.slot[0] = lpre_result(lpre_delta(h2, value), 5'd0, LPRE_EW_NONE, 5'd0);
                    c.slot[1] = lpre_result(lpre_delta(h1, value), 5'd0, LPRE_EW_NONE, 5'd0);
                    c.slot[2] = lpre_result(lpre_delta(h0, value), 5'd0, LPRE_EW_NONE, 5'd0);
                    c.slot[3] = lpre_result(lpre_delta(latest, value), 5'd0, LPRE_EW_NONE, 5'd0);
                end
                default:
                begin
                    c.slot[0] = '0;
                end
            endcase
            c.count = (len[2:0] <= 3'd4) ? len[2:0] : 3'd0;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lpre_front.sv
// ----------------------------------------------------------------------------
// lpre_front
// Accepts code lengths, tracks the pending run and builds one queue
// transaction holding every pretree result the item causes.
// ----------------------------------------------------------------------------
`default_nettype none

module lpre_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [4:0]         new_length,
    input  wire logic [4:0]         prev_length,
    input  wire logic               final_item,
    input  wire logic               queue_full,
    output logic                    push,
    output lpre_pkg::lpre_cmd_t     push_cmd
);
    import lpre_pkg::*;

    logic [4:0] run_value_reg;
    logic [4:0] run_value_next;
    logic [5:0] run_length_reg;
    logic [5:0] run_length_next;
    logic [4:0] latest_prev_reg;
    logic [4:0] hist_reg [LPRE_HIST_DEPTH];

    logic       accept;
    logic       flush_now;
    logic [5:0] len_inc;
    logic [5:0] len_after;
    logic       early_zero;
    logic       early_same;
    logic [2:0] last_idx;
    lpre_cmd_t  cmd_first;
    lpre_cmd_t  cmd_fin;
    lpre_cmd_t  cmd;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        flush_now = (run_length_reg != 6'd0) && (new_length != run_value_reg);
        cmd_first = flush_now ? lpre_flush(run_length_reg, run_value_reg, latest_prev_reg,
                                           hist_reg[0], hist_reg[1], hist_reg[2],
                                           hist_reg[3])
                              : '0;
        len_inc    = flush_now ? 6'd1 : run_length_reg + 6'd1;
        early_zero = (new_length == 5'd0) && (len_inc > LPRE_ZRUN_MAX);
        early_same = (new_length != 5'd0) && (len_inc > LPRE_SRUN_MAX);
        len_after  = (early_zero || early_same) ? 6'd1 : len_inc;

        cmd = cmd_first;
        if (early_zero)
            cmd = lpre_append(cmd, lpre_result(LPRE_SYM_ZRUN_LONG,
                                               5'(LPRE_ZRUN_MAX - LPRE_ZRUN_LONG_BASE),
                                               LPRE_EW_LONG, 5'd0));
        // oldest history slot is read before it shifts out
        if (early_same)
            cmd = lpre_append(cmd, lpre_result(LPRE_SYM_SAME_RUN,
                                               5'(LPRE_SRUN_MAX - LPRE_RUN_MIN),
                                               LPRE_EW_SAME,
                                               lpre_delta(hist_reg[3], new_length)));

        cmd_fin = lpre_flush(len_after, new_length, prev_length, latest_prev_reg,
                             hist_reg[0], hist_reg[1], hist_reg[2]);
        if (final_item)
        begin
            for (int i = 0; i < LPRE_HIST_DEPTH; i++)
            begin
                if (3'(i) < cmd_fin.count)
                    cmd = lpre_append(cmd, cmd_fin.slot[i]);
            end
        end

        last_idx = cmd.count - 3'd1;
        if (final_item && (cmd.count != 3'd0))
            cmd.slot[last_idx].done = 1'b1;

        run_value_next  = new_length;
        run_length_next = final_item ? 6'd0 : len_after;
    end

    assign push     = accept && (cmd.count != 3'd0);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg  <= '0;
            run_length_reg <= '0;
        end
        else if (accept)
        begin
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
        end
    end

    // history of previous lengths, payload only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            latest_prev_reg <= prev_length;
            hist_reg[0]     <= latest_prev_reg;
            for (int i = 1; i < LPRE_HIST_DEPTH; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

endmodule

`default_nettype wire

>>> rtl/lpre_queue.sv
// ----------------------------------------------------------------------------
// lpre_queue
// Short FIFO of result transactions between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lpre_queue #(
    parameter int unsigned DEPTH = lpre_pkg::LPRE_QUEUE_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire lpre_pkg::lpre_cmd_t    push_cmd,
    output logic                        full,
    input  wire logic                   pop,
    output lpre_pkg::lpre_cmd_t         head,
    output logic                        empty
);
    import lpre_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lpre_cmd_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

>>> rtl/lpre_back.sv
// ----------------------------------------------------------------------------
// lpre_back
// Walks the slots of the head transaction and issues one result per cycle
// while out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpre_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lpre_pkg::lpre_cmd_t    head,
    input  wire logic                   empty,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [4:0]                  pretree_symbol,
    output logic [4:0]                  extra_value,
    output logic [2:0]                  extra_width,
    output logic [4:0]                  run_delta_symbol,
    output logic                        table_done
);
    import lpre_pkg::*;

    logic [2:0]     slot_idx_reg;
    logic [2:0]     slot_idx_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    lpre_result_t   result_reg;
    logic           load;
    logic           last_slot;

    assign load      = !empty && (!out_valid_reg || !out_stall);
    assign last_slot = (slot_idx_reg == head.count - 3'd1);
    assign pop       = load && last_slot;

    always_comb
    begin
        slot_idx_next  = slot_idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            slot_idx_next  = last_slot ? 3'd0 : slot_idx_reg + 3'd1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_idx_reg  <= slot_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= head.slot[slot_idx_reg];
    end

    assign out_valid        = out_valid_reg;
    assign pretree_symbol   = result_reg.symbol;
    assign extra_value      = result_reg.extra_value;
    assign extra_width      = result_reg.extra_width;
    assign run_delta_symbol = result_reg.run_delta;
    assign table_done       = result_reg.done;

endmodule

`default_nettype wire

>>> rtl/lzx_pretree_length_run_encoder_unit.sv
// ----------------------------------------------------------------------------
// lzx_pretree_length_run_encoder_unit
// Turns a stream of code lengths into LZX pretree symbols with run coding.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    new_length, prev_length, final_item
// out       source     out_valid / out_stall  pretree_symbol, extra_value,
//                                             extra_width, run_delta_symbol,
//                                             table_done
//
// One code length is taken every cycle while the result queue has room.
// An item's results pass through a queue entry and the output register; the back
// part issues one result per cycle while out_stall is low, up to five per item.
// QUEUE_DEPTH transactions of results sit between the two parts; in_stall
// rises only when that queue is full.
// Reset clears the pending run and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lzx_pretree_length_run_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = lpre_pkg::LPRE_QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [4:0] new_length,
    input  wire logic [4:0] prev_length,
    input  wire logic       final_item,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [4:0]      pretree_symbol,
    output logic [4:0]      extra_value,
    output logic [2:0]      extra_width,
    output logic [4:0]      run_delta_symbol,
    output logic            table_done
);
    import lpre_pkg::*;

    logic       push;
    lpre_cmd_t  push_cmd;
    logic       queue_full;
    logic       pop;
    lpre_cmd_t  head;
    logic       empty;

    lpre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .new_length  (new_length),
        .prev_length (prev_length),
        .final_item  (final_item),
        .queue_full  (queue_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    lpre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    lpre_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .empty            (empty),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pretree_symbol   (pretree_symbol),
        .extra_value      (extra_value),
        .extra_width      (extra_width),
        .run_delta_symbol (run_delta_symbol),
        .table_done       (table_done)
    );

endmodule

`default_nettype wire

>>> rtl/lpre_checker.sv
// ----------------------------------------------------------------------------
// lpre_checker
// Port-level checks of the pretree length run encoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lzx_pretree_length_run_encoder_unit_assert.svh"

module lpre_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [4:0] pretree_symbol,
    input  wire logic [4:0] extra_value,
    input  wire logic [2:0] extra_width,
    input  wire logic [4:0] run_delta_symbol,
    input  wire logic       table_done
);
    import lpre_pkg::*;

    `LPRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "out_valid dropped while stalled")

    `LPRE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(pretree_symbol) && $stable(extra_value) && $stable(extra_width) && $stable(run_delta_symbol) && $stable(table_done), "result changed while stalled")

    `LPRE_ASSERT_IMPLY(a_delta_plain, clk, rst_n, out_valid && (pretree_symbol < LPRE_SYM_ZRUN_SHORT), (extra_width == LPRE_EW_NONE) && (extra_value == 5'd0) && (run_delta_symbol == 5'd0), "delta symbol carries run fields")

    `LPRE_ASSERT_IMPLY(a_short_zero, clk, rst_n, out_valid && (pretree_symbol == LPRE_SYM_ZRUN_SHORT), (extra_width == LPRE_EW_SHORT) && (extra_value <= 5'd15) && (run_delta_symbol == 5'd0), "bad short zero run fields")

    `LPRE_ASSERT_IMPLY(a_same_run, clk, rst_n, out_valid && (pretree_symbol == LPRE_SYM_SAME_RUN), (extra_width == LPRE_EW_SAME) && (run_delta_symbol <= 5'd16) && !table_done, "bad same run fields")

endmodule

bind lzx_pretree_length_run_encoder_unit lpre_checker u_lpre_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pretree_symbol   (pretree_symbol),
    .extra_value      (extra_value),
    .extra_width      (extra_width),
    .run_delta_symbol (run_delta_symbol),
    .table_done       (table_done)
);

`default_nettype wire

>>> verif/lzx_pretree_length_run_encoder_unit_test.sv
// ----------------------------------------------------------------------------
// LZX pretree length run encoder unit test
// Streams code lengths into the encoder: a short table of hand-picked cases,
// then random runs of zeros, repeated lengths and noise. A behavioral model
// predicts the symbols of all untyped rows, and the scoreboard checks each
// transaction on the result port, while both ports idle and stall at random.
// ----------------------------------------------------------------------------
module lzx_pretree_length_run_encoder_unit_test;

    import lpre_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 90;
    localparam int SQUEEZE_AFTER = 5;
    localparam int SQUEEZE_LEN   = 200;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [4:0] len;
        logic [4:0] old;
        logic       fin;
        logic       typed;
        logic [4:0] sym;
    } table_row_t;

    // typed rows: one delta symbol, last of its table
    localparam table_row_t DIRECTED [0:24] = '{
        '{5'd5,  5'd3,  1'b1, 1'b1, 5'd15},
        '{5'd31, 5'd0,  1'b1, 1'b1, 5'd3},
        '{5'd0,  5'd31, 1'b1, 1'b1, 5'd14},
        '{5'd16, 5'd16, 1'b1, 1'b1, 5'd0},
        '{5'd0,  5'd0,  1'b1, 1'b1, 5'd0},
        // repeat run of five closed by a new length
        '{5'd7,  5'd1,  1'b0, 1'b0, 5'd0},
        '{5'd7,  5'd2,  1'b0, 1'b0, 5'd0},
        '{5'd7,  5'd3,  1'b0, 1'b0, 5'd0},
        '{5'd7,  5'd4,  1'b0, 1'b0, 5'd0},
        '{5'd7,  5'd5,  1'b0, 1'b0, 5'd0},
        '{5'd9,  5'd9,  1'b1, 1'b0, 5'd0},
        // six equal lengths: repeat symbol issued before the flush
        '{5'd3,  5'd16, 1'b0, 1'b0, 5'd0},
        '{5'd3,  5'd0,  1'b0, 1'b0, 5'd0},
        '{5'd3,  5'd31, 1'b0, 1'b0, 5'd0},
        '{5'd3,  5'd8,  1'b0, 1'b0, 5'd0},
        '{5'd3,  5'd2,  1'b0, 1'b0, 5'd0},
        '{5'd3,  5'd17, 1'b1, 1'b0, 5'd0},
        // short zero run flushed by the end of the table
        '{5'd0,  5'd1,  1'b0, 1'b0, 5'd0},
        '{5'd0,  5'd2,  1'b0, 1'b0, 5'd0},
        '{5'd0,  5'd3,  1'b0, 1'b0, 5'd0},
        '{5'd0,  5'd4,  1'b0, 1'b0, 5'd0},
        '{5'd0,  5'd5,  1'b1, 1'b0, 5'd0},
        // two short runs of plain deltas
        '{5'd4,  5'd6,  1'b0, 1'b0, 5'd0},
        '{5'd4,  5'd7,  1'b0, 1'b0, 5'd0},
        '{5'd2,  5'd1,  1'b1, 1'b0, 5'd0}
    };

    logic       clk              = 1'b0;
    logic       rst_n            = 1'b0;
    logic       in_valid         = 1'b0;
    logic       in_stall;
    logic [4:0] new_length       = 5'd0;
    logic [4:0] prev_length      = 5'd0;
    logic       final_item       = 1'b0;
    logic       out_valid;
    logic       out_stall        = 1'b0;
    logic [4:0] pretree_symbol;
    logic [4:0] extra_value;
    logic [2:0] extra_width;
    logic [4:0] run_delta_symbol;
    logic       table_done;

    // encoder state as seen by the model
    logic [4:0]   cur_value   = 5'd0;
    logic [5:0]   cur_count   = 6'd0;
    logic [4:0]   newest_prev = 5'd0;
    logic [4:0]   older_prev [0:4] = '{default: 5'd0};

    lpre_result_t step_syms [$];
    lpre_result_t expected_syms [$];

    int  items_taken  = 0;
    int  syms_seen    = 0;
    int  zero_short   = 0;
    int  zero_long    = 0;
    int  repeat_runs  = 0;
    int  tables_done  = 0;
    int  fails        = 0;
    bit  tx_calm      = 1'b0;
    bit  squeeze_done = 1'b0;

    lzx_pretree_length_run_encoder_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .new_length       (new_length),
        .prev_length      (prev_length),
        .final_item       (final_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pretree_symbol   (pretree_symbol),
        .extra_value      (extra_value),
        .extra_width      (extra_width),
        .run_delta_symbol (run_delta_symbol),
        .table_done       (table_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [4:0] mod17_delta(logic [4:0] p, logic [4:0] v);
        int s;
        s = (int'(p) + 34 - int'(v)) % 17;
        return 5'(s);
    endfunction

    function automatic lpre_result_t make_sym(logic [4:0] sym, logic [4:0] ev,
                                              logic [2:0] ew, logic [4:0] rd);
        lpre_result_t r;
        r.symbol      = sym;
        r.extra_value = ev;
        r.extra_width = ew;
        r.run_delta   = rd;
        r.done        = 1'b0;
        return r;
    endfunction

    function automatic string sym_text(lpre_result_t r);
        return $sformatf("sym %0d ev %0d ew %0d rd %0d done %0d", r.symbol,
                         r.extra_value, r.extra_width, r.run_delta, r.done);
    endfunction

    // prev length of the pending element k places before the newest
    function automatic logic [4:0] prev_back(int k);
        if (k == 0)
            return newest_prev;
        return older_prev[k - 1];
    endfunction

    task automatic close_run();
        int r;
        if (cur_count >= LPRE_FLUSH_RUN_MIN)
        begin
            r = int'(cur_count) - 1;
            if (cur_value == 5'd0)
            begin
                if (r > int'(LPRE_ZRUN_MAX))
                    r = int'(LPRE_ZRUN_MAX);
                if (r <= int'(LPRE_ZRUN_SHORT_MAX))
                    step_syms.push_back(make_sym(LPRE_SYM_ZRUN_SHORT,
                        5'(r - int'(LPRE_RUN_MIN)), LPRE_EW_SHORT, 5'd0));
                else
                    step_syms.push_back(make_sym(LPRE_SYM_ZRUN_LONG,
                        5'(r - int'(LPRE_ZRUN_LONG_BASE)), LPRE_EW_LONG, 5'd0));
            end
            else
            begin
                step_syms.push_back(make_sym(LPRE_SYM_SAME_RUN, 5'd0, LPRE_EW_SAME,
                    mod17_delta(older_prev[3], cur_value)));
            end
            step_syms.push_back(make_sym(mod17_delta(newest_prev, cur_value), 5'd0,
                LPRE_EW_NONE, 5'd0));
        end
        else
        begin
            // oldest pending element first
            for (int j = 0; j < int'(cur_count); j++)
                step_syms.push_back(make_sym(
                    mod17_delta(prev_back(int'(cur_count) - 1 - j), cur_value),
                    5'd0, LPRE_EW_NONE, 5'd0));
        end
        cur_count = 6'd0;
    endtask

    // Work out the pretree symbols one code length makes decidable.
    task automatic encode_length(input logic [4:0] len, input logic [4:0] old,
                                 input logic fin);
        step_syms.delete();
        if (cur_count != 6'd0 && len != cur_value)
            close_run();
        for (int k = 4; k > 0; k--)
            older_prev[k] = older_prev[k - 1];
        older_prev[0] = newest_prev;
        newest_prev   = old;
        cur_value     = len;
        cur_count     = cur_count + 6'd1;
        if (len == 5'd0 && cur_count > LPRE_ZRUN_MAX)
        begin
            step_syms.push_back(make_sym(LPRE_SYM_ZRUN_LONG, 5'd31, LPRE_EW_LONG, 5'd0));
            cur_count = 6'd1;
        end
        else if (len != 5'd0 && cur_count > LPRE_SRUN_MAX)
        begin
            step_syms.push_back(make_sym(LPRE_SYM_SAME_RUN, 5'd1, LPRE_EW_SAME,
                mod17_delta(older_prev[4], len)));
            cur_count = 6'd1;
        end
        if (fin)
        begin
            close_run();
            step_syms[step_syms.size() - 1].done = 1'b1;
        end
    endtask

    // Offer one code length, hold it until taken, then book its symbols.
    task automatic offer(input logic [4:0] len, input logic [4:0] old, input logic fin,
                         input logic typed, input logic [4:0] tsym);
        int gap;
        lpre_result_t t;
        gap = tx_calm ? 0 : idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        new_length  <= len;
        prev_length <= old;
        final_item  <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_taken++;
        encode_length(len, old, fin);
        if (typed)
        begin
            t      = make_sym(tsym, 5'd0, LPRE_EW_NONE, 5'd0);
            t.done = 1'b1;
            expected_syms.push_back(t);
        end
        else
        begin
            foreach (step_syms[k])
                expected_syms.push_back(step_syms[k]);
        end
    endtask

    task automatic report_error(input string what, input lpre_result_t want,
                                input lpre_result_t got);
        fails++;
        if (fails <= 10)
            $display("%0t %s: expected %s, got %s",
                     $time, what, sym_text(want), sym_text(got));
    endtask

    // scoreboard on the result port
    always @(posedge clk)
    begin
        lpre_result_t got;
        lpre_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.symbol      = pretree_symbol;
            got.extra_value = extra_value;
            got.extra_width = extra_width;
            got.run_delta   = run_delta_symbol;
            got.done        = table_done;
            syms_seen++;
            if (pretree_symbol == LPRE_SYM_ZRUN_SHORT)
                zero_short++;
            if (pretree_symbol == LPRE_SYM_ZRUN_LONG)
                zero_long++;
            if (pretree_symbol == LPRE_SYM_SAME_RUN)
                repeat_runs++;
            if (table_done)
                tables_done++;
            if (expected_syms.size() == 0)
            begin
                report_error("unexpected transaction", '0, got);
            end
            else
            begin
                want = expected_syms.pop_front();
                if (got.symbol !== want.symbol || got.extra_value !== want.extra_value ||
                    got.extra_width !== want.extra_width ||
                    got.run_delta !== want.run_delta || got.done !== want.done)
                    report_error("mismatch", want, got);
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back up the input
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!squeeze_done && items_taken >= SQUEEZE_AFTER)
            begin
                out_stall <= 1'b1;
                repeat (SQUEEZE_LEN) @(negedge clk);
                squeeze_done = 1'b1;
                hold = 0;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            else
            begin
                hold = idle_gap();
                out_stall <= (hold > 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d symbols still expected",
                 CYCLE_LIMIT, expected_syms.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        table_row_t row;
        int         group;
        int         glen;
        logic [4:0] gval;
        bit         noise;
        bit         fin_last;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            offer(row.len, row.old, row.fin, row.typed, row.sym);
        end

        group = 0;
        while (items_taken < $size(DIRECTED) + RANDOM_ITEMS)
        begin
            tx_calm  = ($urandom_range(0, 4) == 0);
            noise    = 1'b0;
            gval     = 5'd0;
            if (group == 3)
            begin
                glen = $urandom_range(52, 55);
            end
            else if (group == 9)
            begin
                glen = $urandom_range(21, 30);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        glen = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20)
                                                           : $urandom_range(1, 8);
                    end
                    3, 4, 5:
                    begin
                        gval = 5'($urandom_range(1, 31));
                        glen = $urandom_range(1, 8);
                    end
                    default:
                    begin
                        noise = 1'b1;
                        glen  = $urandom_range(1, 4);
                    end
                endcase
            end
            fin_last = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < glen; k++)
                offer(noise ? 5'($urandom_range(0, 31)) : gval, 5'($urandom_range(0, 31)),
                      (k == glen - 1) ? fin_last : (noise && $urandom_range(0, 7) == 0),
                      1'b0, 5'd0);
            group++;
        end
        // close the last table
        offer(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 1'b1, 1'b0, 5'd0);
        @(negedge clk);
        in_valid <= 1'b0;

        while (expected_syms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d code lengths in %0d tables, checked %0d pretree symbols",
                 items_taken, tables_done, syms_seen);
        $display("Zero runs %0d short / %0d long, repeat runs %0d, mismatches %0d",
                 zero_short, zero_long, repeat_runs, fails);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
